FILE: rtl/core/swpr_pkg.sv
// ----------------------------------------------------------------------------
// swpr_pkg
// Shared constants and controller/datapath handshake types for the
// sliding window peak rate counter.
// ----------------------------------------------------------------------------
package swpr_pkg;

	// default sizing
	localparam int FIFO_DEPTH_DEF = 1024;
	localparam int STAMP_BITS_DEF = 40;

	// fixed field widths
	localparam int WIN_BITS   = 24;
	localparam int CLASS_BITS = 4;
	localparam int ERR_BITS   = 32;

	// window register value after reset
	localparam logic [WIN_BITS-1:0] WIN_RESET = 24'd60;

	// status class that counts as a server error
	localparam logic [CLASS_BITS-1:0] CLASS_SERVER_ERR = 4'd5;

	// commands from controller to datapath
	typedef struct packed {
		logic load;    // capture the input transaction
		logic pop;     // drop the oldest stamp, it lies outside the window
		logic push;    // store the new stamp
		logic finish;  // update peak and error count, load the result register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic evict;   // oldest stamp present and outside the window
	} stat_t;

endpackage

FILE: rtl/core/swpr_ctrl.sv
// ----------------------------------------------------------------------------
// swpr_ctrl
// Controller state machine: accepts a transaction, steps the eviction loop
// one stamp per cycle, pushes, then hands the result to the output register.
// ----------------------------------------------------------------------------
module swpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  swpr_pkg::stat_t   stat,
	output swpr_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.evict) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.push = 1'b1;
					state_d  = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.finish | (out_valid_q & ~out_ready);
		end
	end

	assign out_valid = out_valid_q;

	// the result register is only loaded when it is free or being drained
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result overwritten while still pending");

endmodule

FILE: rtl/core/swpr_dp.sv
// ----------------------------------------------------------------------------
// swpr_dp
// Datapath: stamp memory with read and write pointers, occupancy, window
// compare, peak record, error counter, overflow flag and result register.
// ----------------------------------------------------------------------------
module swpr_dp #(
	parameter int FIFO_DEPTH = swpr_pkg::FIFO_DEPTH_DEF,
	parameter int STAMP_BITS = swpr_pkg::STAMP_BITS_DEF,
	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
	localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swpr_pkg::cmd_t                  cmd,
	output swpr_pkg::stat_t                 stat,
	input  logic                            cfg_wen,
	input  logic [swpr_pkg::WIN_BITS-1:0]   cfg_wdata,
	input  logic [STAMP_BITS-1:0]           event_time,
	input  logic [swpr_pkg::CLASS_BITS-1:0] status_class,
	output logic [CW-1:0]                   window_count,
	output logic [CW-1:0]                   peak_count,
	output logic [STAMP_BITS-1:0]           peak_start,
	output logic [STAMP_BITS-1:0]           peak_end,
	output logic [swpr_pkg::ERR_BITS-1:0]   error_total,
	output logic                            overflow
);

	localparam int WCMP = (STAMP_BITS > swpr_pkg::WIN_BITS) ? STAMP_BITS
	                                                        : swpr_pkg::WIN_BITS;
	localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] OCC_FULL = CW'(FIFO_DEPTH);

	logic [STAMP_BITS-1:0]           mem_q [FIFO_DEPTH];
	logic [STAMP_BITS-1:0]           head_q;
	logic [STAMP_BITS-1:0]           time_q;
	logic [swpr_pkg::CLASS_BITS-1:0] class_q;
	logic [swpr_pkg::WIN_BITS-1:0]   win_q;
	logic [PW-1:0]                   rd_ptr_q;
	logic [PW-1:0]                   wr_ptr_q;
	logic [CW-1:0]                   occ_q;
	logic                            was_empty_q;
	logic [CW-1:0]                   best_count_q;
	logic [STAMP_BITS-1:0]           best_start_q;
	logic [STAMP_BITS-1:0]           best_end_q;
	logic [swpr_pkg::ERR_BITS-1:0]   err_q;
	logic                            ovf_q;
	logic [CW-1:0]                   res_count_q;
	logic [CW-1:0]                   res_peak_q;
	logic [STAMP_BITS-1:0]           res_start_q;
	logic [STAMP_BITS-1:0]           res_end_q;
	logic [swpr_pkg::ERR_BITS-1:0]   res_err_q;
	logic                            res_ovf_q;

	logic [PW-1:0]         rd_inc;
	logic [PW-1:0]         wr_inc;
	logic [PW-1:0]         rd_addr;
	logic                  full;
	logic                  adv_rd;
	logic [STAMP_BITS:0]   diff;
	logic [STAMP_BITS-1:0] win_start;
	logic                  new_peak;
	logic [CW-1:0]         best_count_d;
	logic [STAMP_BITS-1:0] best_start_d;
	logic [STAMP_BITS-1:0] best_end_d;
	logic [swpr_pkg::ERR_BITS-1:0] err_d;

	// pointer wrap
	assign rd_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
	assign wr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign full   = (occ_q == OCC_FULL);
	assign adv_rd = cmd.pop | (cmd.push & full);

	// read port follows the head of the queue, including a head about to move
	assign rd_addr = adv_rd ? rd_inc : rd_ptr_q;

	// window check on the oldest stamp; a borrow means the stamp is newer
	assign diff = {1'b0, time_q} - {1'b0, head_q};
	assign stat.evict = (occ_q != '0) && !diff[STAMP_BITS] &&
	                    (WCMP'(diff[STAMP_BITS-1:0]) > WCMP'(win_q));

	// peak and error updates for the finishing transaction
	assign win_start    = was_empty_q ? time_q : head_q;
	assign new_peak     = occ_q > best_count_q;
	assign best_count_d = new_peak ? occ_q : best_count_q;
	assign best_start_d = new_peak ? win_start : best_start_q;
	assign best_end_d   = new_peak ? time_q : best_end_q;
	assign err_d        = ((class_q == swpr_pkg::CLASS_SERVER_ERR) && (err_q != '1)) ?
	                      err_q + 1'b1 : err_q;

	// stamp memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[wr_ptr_q] <= time_q;
		end
		head_q <= mem_q[rd_addr];
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			time_q  <= event_time;
			class_q <= status_class;
		end
		if (cmd.push) begin
			was_empty_q <= (occ_q == '0);
		end
	end

	// queue control, peak record, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q        <= swpr_pkg::WIN_RESET;
			rd_ptr_q     <= '0;
			wr_ptr_q     <= '0;
			occ_q        <= '0;
			best_count_q <= '0;
			best_start_q <= '0;
			best_end_q   <= '0;
			err_q        <= '0;
			ovf_q        <= 1'b0;
		end else begin
			if (cfg_wen) begin
				win_q <= cfg_wdata;
			end
			if (adv_rd) begin
				rd_ptr_q <= rd_inc;
			end
			if (cmd.pop) begin
				occ_q <= occ_q - 1'b1;
			end else if (cmd.push) begin
				wr_ptr_q <= wr_inc;
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					occ_q <= occ_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				best_count_q <= best_count_d;
				best_start_q <= best_start_d;
				best_end_q   <= best_end_d;
				err_q        <= err_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_count_q <= occ_q;
			res_peak_q  <= best_count_d;
			res_start_q <= best_start_d;
			res_end_q   <= best_end_d;
			res_err_q   <= err_d;
			res_ovf_q   <= ovf_q;
		end
	end

	assign window_count = res_count_q;
	assign peak_count   = res_peak_q;
	assign peak_start   = res_start_q;
	assign peak_end     = res_end_q;
	assign error_total  = res_err_q;
	assign overflow     = res_ovf_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("occupancy above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (occ_q != '0))
		else $error("pop from empty queue");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> (occ_q != '0))
		else $error("queue empty after push");

	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (best_count_q >= $past(best_count_q)))
		else $error("peak count decreased");

endmodule

FILE: rtl/core/sliding_window_peak_rate_counter.sv
// ----------------------------------------------------------------------------
// sliding_window_peak_rate_counter
// Tracks how many events fall inside a sliding time window and records the
// busiest window seen, plus a saturating server error count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event: timestamp and status
//   class. Output channel (out_valid/out_ready) returns one result per event:
//   current window count, peak count with its start and end stamps, error
//   total and a sticky overflow flag.
//   Steps: after acceptance the eviction loop removes the stamps that leave
//   the window, reading one stamp per cycle from the single read port of the
//   stamp memory, then the new stamp is pushed and the result register is
//   loaded. Each stamp leaves once.
//   The result sits in an output register; the next event is accepted while
//   it waits. If the receiver stalls, processing holds at the final step
//   until the pending result is taken.
//   Reset clears pointers, counts, peak record and flags and sets the window
//   to 60 seconds; no memory clearing pass is needed. cfg_wen writes the
//   window width in seconds and should be used only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_peak_rate_counter #(
	parameter int FIFO_DEPTH = swpr_pkg::FIFO_DEPTH_DEF,
	parameter int STAMP_BITS = swpr_pkg::STAMP_BITS_DEF,
	localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [swpr_pkg::WIN_BITS-1:0]   cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [STAMP_BITS-1:0]           event_time,
	input  logic [swpr_pkg::CLASS_BITS-1:0] status_class,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [CW-1:0]                   window_count,
	output logic [CW-1:0]                   peak_count,
	output logic [STAMP_BITS-1:0]           peak_start,
	output logic [STAMP_BITS-1:0]           peak_end,
	output logic [swpr_pkg::ERR_BITS-1:0]   error_total,
	output logic                            overflow
);

	swpr_pkg::cmd_t  cmd;
	swpr_pkg::stat_t stat;

	// controller
	swpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	swpr_dp #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.STAMP_BITS (STAMP_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.event_time   (event_time),
		.status_class (status_class),
		.window_count (window_count),
		.peak_count   (peak_count),
		.peak_start   (peak_start),
		.peak_end     (peak_end),
		.error_total  (error_total),
		.overflow     (overflow)
	);

endmodule

FILE: tb/tb_sliding_window_peak_rate_counter.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_peak_rate_counter
// Self-checking bench for the sliding window peak rate counter. A queue-fed
// driver sends event transactions with random gaps, and a monitor predicts
// every result from its own copy of the stamp FIFO, peak record, error count
// and overflow flag, then compares each result field by field. Phases run
// the reset window, the widest window with a FIFO overflow burst, a zero
// window and a small random window.
// ----------------------------------------------------------------------------
module tb_sliding_window_peak_rate_counter;

	localparam int RING_DEPTH  = swpr_pkg::FIFO_DEPTH_DEF;
	localparam int STAMP_W     = swpr_pkg::STAMP_BITS_DEF;
	localparam int COUNT_W     = $clog2(RING_DEPTH + 1);
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [STAMP_W-1:0]              stamp;
		logic [swpr_pkg::CLASS_BITS-1:0] cls;
	} event_t;

	typedef struct packed {
		logic [COUNT_W-1:0]            wcount;
		logic [COUNT_W-1:0]            pcount;
		logic [STAMP_W-1:0]            pstart;
		logic [STAMP_W-1:0]            pend;
		logic [swpr_pkg::ERR_BITS-1:0] errs;
		logic                          ovf;
	} tally_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wen = 1'b0;
	logic [swpr_pkg::WIN_BITS-1:0]   cfg_wdata = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [STAMP_W-1:0]              event_time = '0;
	logic [swpr_pkg::CLASS_BITS-1:0] status_class = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [COUNT_W-1:0]              window_count;
	logic [COUNT_W-1:0]              peak_count;
	logic [STAMP_W-1:0]              peak_start;
	logic [STAMP_W-1:0]              peak_end;
	logic [swpr_pkg::ERR_BITS-1:0]   error_total;
	logic                            overflow;

	// predicted block state
	logic [STAMP_W-1:0]            stamp_ring [RING_DEPTH];
	int                            ring_head = 0;
	int                            ring_tail = 0;
	int                            ring_fill = 0;
	logic [swpr_pkg::WIN_BITS-1:0] span_limit = swpr_pkg::WIN_RESET;
	int                            top_count = 0;
	logic [STAMP_W-1:0]            top_first = '0;
	logic [STAMP_W-1:0]            top_last = '0;
	logic [swpr_pkg::ERR_BITS-1:0] err_tally = '0;
	logic                          spill_seen = 1'b0;

	event_t pending_events [$];
	tally_t expected_tallies [$];
	logic   in_took = 1'b0;
	int     cycle_count = 0;
	int     fail_count = 0;
	int     events_sent = 0;
	int     results_seen = 0;
	logic [STAMP_W-1:0] clock_now = '0;
	logic   calm;

	sliding_window_peak_rate_counter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.event_time   (event_time),
		.status_class (status_class),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.window_count (window_count),
		.peak_count   (peak_count),
		.peak_start   (peak_start),
		.peak_end     (peak_end),
		.error_total  (error_total),
		.overflow     (overflow)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// stretches with no idling on either side
	assign calm = (cycle_count % 6000) < 1500;

	// evict stale stamps, push the new one, update peak, errors and overflow
	function automatic tally_t advance_window(input logic [STAMP_W-1:0] t,
			input logic [swpr_pkg::CLASS_BITS-1:0] cls);
		tally_t             r;
		logic [STAMP_W-1:0] oldest;
		bit                 stop;
		stop = 1'b0;
		while (ring_fill != 0 && !stop) begin
			oldest = stamp_ring[ring_head];
			// a stamp later than the new one stays inside the window
			if (t >= oldest && (t - oldest) > STAMP_W'(span_limit)) begin
				ring_head = (ring_head + 1) % RING_DEPTH;
				ring_fill--;
			end else begin
				stop = 1'b1;
			end
		end
		// full ring: drop the oldest early and remember it
		if (ring_fill >= RING_DEPTH) begin
			ring_head = (ring_head + 1) % RING_DEPTH;
			ring_fill--;
			spill_seen = 1'b1;
		end
		stamp_ring[ring_tail] = t;
		ring_tail = (ring_tail + 1) % RING_DEPTH;
		ring_fill++;
		if (ring_fill > top_count) begin
			top_count = ring_fill;
			top_first = stamp_ring[ring_head];
			top_last  = t;
		end
		if (cls == swpr_pkg::CLASS_SERVER_ERR && err_tally != '1)
			err_tally++;
		r.wcount = COUNT_W'(ring_fill);
		r.pcount = COUNT_W'(top_count);
		r.pstart = top_first;
		r.pend   = top_last;
		r.errs   = err_tally;
		r.ovf    = spill_seen;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
			results_seen, what, got, want);
		fail_count++;
	endtask

	task automatic add_event(input logic [STAMP_W-1:0] t,
			input logic [swpr_pkg::CLASS_BITS-1:0] cls);
		event_t e;
		e.stamp = t;
		e.cls   = cls;
		pending_events.push_back(e);
		events_sent++;
	endtask

	// mostly rising stamps with random steps, a few steps backwards
	task automatic queue_burst(input int count, input int step_hi);
		logic [swpr_pkg::CLASS_BITS-1:0] cls;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 3 && clock_now >= 50)
				clock_now = clock_now - STAMP_W'($urandom_range(1, 50));
			else
				clock_now = clock_now + STAMP_W'($urandom_range(0, step_hi));
			cls = ($urandom_range(0, 3) == 0) ? swpr_pkg::CLASS_SERVER_ERR :
			      swpr_pkg::CLASS_BITS'($urandom_range(0, 15));
			add_event(clock_now, cls);
		end
	endtask

	// block is idle once nothing is queued, driven or outstanding
	task automatic wait_drained();
		@(posedge clk);
		while (pending_events.size() != 0 || in_valid || expected_tallies.size() != 0)
			@(posedge clk);
	endtask

	task automatic apply_window(input logic [swpr_pkg::WIN_BITS-1:0] w);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= w;
		span_limit = w;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// input driver and output back-pressure
	always @(negedge clk) begin : drive_ports
		event_t nxt;
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (pending_events.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
					nxt = pending_events.pop_front();
					in_valid     <= 1'b1;
					event_time   <= nxt.stamp;
					status_class <= nxt.cls;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 10);
		end
	end

	// monitor: predict on each input transaction, check each output transaction
	always @(posedge clk) begin : watch_ports
		tally_t want;
		in_took <= in_valid && in_ready;
		if (in_valid && in_ready)
			expected_tallies.push_back(advance_window(event_time, status_class));
		if (out_valid && out_ready) begin
			results_seen++;
			if (expected_tallies.size() == 0) begin
				report_mismatch("result with nothing expected", 64'd0, 64'd0);
			end else begin
				want = expected_tallies.pop_front();
				if (window_count !== want.wcount)
					report_mismatch("window_count", 64'(window_count), 64'(want.wcount));
				if (peak_count !== want.pcount)
					report_mismatch("peak_count", 64'(peak_count), 64'(want.pcount));
				if (peak_start !== want.pstart)
					report_mismatch("peak_start", 64'(peak_start), 64'(want.pstart));
				if (peak_end !== want.pend)
					report_mismatch("peak_end", 64'(peak_end), 64'(want.pend));
				if (error_total !== want.errs)
					report_mismatch("error_total", 64'(error_total), 64'(want.errs));
				if (overflow !== want.ovf)
					report_mismatch("overflow", 64'(overflow), 64'(want.ovf));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_tallies.size());
			$display("tb_sliding_window_peak_rate_counter failed");
			$finish;
		end
	end

	// stimulus phases
	initial begin : run_phases
		int span_mid;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed events under the reset window of 60 s
		add_event(40'd0, 4'd0);
		add_event(40'd0, swpr_pkg::CLASS_SERVER_ERR);
		add_event(40'd30, 4'd15);
		add_event(40'd60, swpr_pkg::CLASS_SERVER_ERR); // span equal to the window stays
		add_event(40'd61, 4'd9);                       // both stamps at 0 leave
		add_event(40'd61, swpr_pkg::CLASS_SERVER_ERR);
		add_event(40'd50, 4'd4);                       // stamp going backwards
		add_event(40'd200, 4'd1);                      // whole window leaves
		add_event(40'd200, 4'd10);
		add_event(40'd260, 4'd11);
		add_event(40'd261, 4'd14);
		add_event('1, swpr_pkg::CLASS_SERVER_ERR);     // largest stamp
		add_event('1, 4'd3);
		add_event(40'h55_5555_5555, 4'd12);            // older than the stored head
		add_event(40'hAA_AAAA_AAAA, 4'd6);
		add_event('1, 4'd7);
		add_event(40'h00_0000_0001, 4'd8);
		wait_drained();

		// widest window: fill the fifo past its depth
		apply_window('1);
		clock_now = STAMP_W'({32'($urandom_range(0, 63)), 32'($urandom)});
		queue_burst(1040, 3);
		wait_drained();

		// zero window: only equal stamps, or stamps later than the new one, share it
		apply_window('0);
		queue_burst(110, 2);
		wait_drained();

		// small random window after a full fifo
		span_mid = $urandom_range(3, 40);
		apply_window(swpr_pkg::WIN_BITS'(span_mid));
		queue_burst(100, 10);
		wait_drained();

		repeat (20) @(posedge clk);
		if (expected_tallies.size() != 0)
			report_mismatch("results never delivered", 64'(expected_tallies.size()), 64'd0);

		$display("covered %0d events and %0d results, windows of 60 s, maximum, 0 s and %0d s",
			events_sent, results_seen, span_mid);
		$display("peak window %0d events, fifo overflow %0s, %0d mismatches",
			top_count, spill_seen ? "reached" : "not reached", fail_count);
		if (fail_count == 0)
			$display("tb_sliding_window_peak_rate_counter passed");
		else
			$display("tb_sliding_window_peak_rate_counter failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/swpr_pkg.sv
rtl/core/swpr_ctrl.sv
rtl/core/swpr_dp.sv
rtl/core/sliding_window_peak_rate_counter.sv
tb/tb_sliding_window_peak_rate_counter.sv
